[hw/rtl/mmts_pkg.sv]
package mmts_pkg;

	// Defaults and fixed field widths.
	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes carried in the kind field. Codes above KIND_QUERY act as queries.
	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_MIN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_MAX = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

	// Sentinels of the running extremes on an empty stack.
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

	// Command broadcast from the sequencer to every cell.
	typedef struct packed {
		logic shift_dn;   // push: every cell takes the value of the cell above it
		logic shift_up;   // pop: every cell takes the value of the cell below it
		logic mark;       // invalidate every cell holding the victim value
		logic swap;       // one round of odd-even compaction
		logic phase_odd;  // which pairs swap in this round
	} cell_ctrl_t;

	// Partial extremes handed along the scan chain.
	typedef struct packed {
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
	} scan_t;

endpackage

[hw/rtl/mmts_cell.sv]
module mmts_cell #(
	parameter int unsigned CNT_W = 5,
	parameter logic        ODD   = 1'b0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmts_pkg::cell_ctrl_t              ctrl,
	input  logic signed [mmts_pkg::DATA_W-1:0] victim,
	input  logic signed [mmts_pkg::DATA_W-1:0] up_data,
	input  logic                              up_valid,
	input  logic signed [mmts_pkg::DATA_W-1:0] dn_data,
	input  logic                              dn_valid,
	output logic signed [mmts_pkg::DATA_W-1:0] data,
	output logic                              valid,
	input  mmts_pkg::scan_t                   scan_in,
	input  logic [CNT_W-1:0]                  scan_n_in,
	output mmts_pkg::scan_t                   scan_out,
	output logic [CNT_W-1:0]                  scan_n_out
);

	logic signed [mmts_pkg::DATA_W-1:0] data_q;
	logic signed [mmts_pkg::DATA_W-1:0] data_d;
	logic                               valid_q;
	logic                               valid_d;
	mmts_pkg::scan_t                    scan_q;
	mmts_pkg::scan_t                    scan_d;
	logic [CNT_W-1:0]                   scan_n_q;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		priority if (ctrl.shift_dn) begin
			data_d  = up_data;
			valid_d = up_valid;
		end else if (ctrl.shift_up) begin
			data_d  = dn_data;
			valid_d = dn_valid;
		end else if (ctrl.mark) begin
			valid_d = valid_q && (data_q != victim);
		end else if (ctrl.swap) begin
			// In each round a cell is either the upper or the lower half of a pair.
			// A hole above a live entry trades places with it, so live entries rise
			// toward the top in their original order.
			if (ctrl.phase_odd == ODD) begin
				if (!valid_q && dn_valid) begin
					data_d  = dn_data;
					valid_d = 1'b1;
				end
			end else if (!up_valid && valid_q) begin
				valid_d = 1'b0;
			end
		end else begin
			data_d  = data_q;
			valid_d = valid_q;
		end
	end

	// Running extremes and live count of this cell and every cell below it.
	always_comb begin
		scan_d = scan_in;
		if (valid_q) begin
			if (data_q < scan_in.lo) begin
				scan_d.lo = data_q;
			end
			if (data_q > scan_in.hi) begin
				scan_d.hi = data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q   <= data_d;
		scan_q   <= scan_d;
		scan_n_q <= scan_n_in + CNT_W'(valid_q);
	end

	assign data       = data_q;
	assign valid      = valid_q;
	assign scan_out   = scan_q;
	assign scan_n_out = scan_n_q;

endmodule

[hw/rtl/min_max_tracking_stack.sv]
// Bounded stack of signed 32-bit values that tracks its running minimum and maximum.
// Each request carries an operation in kind (push, pop, pop-minimum, pop-maximum or
// query; codes above query act as a query) and, for a push, the value in value. Every
// request produces exactly one response with the status (ok, overflow on a push that
// finds the stack at its limit, underflow on any other operation on an empty stack),
// the top entry, the minimum, the maximum, the entry count and an empty flag. An empty
// stack reports a top of zero, a minimum of 2147483647 and a maximum of -2147483648.
// The stack is a row of DEPTH cells, cell 0 holding the top. Push and pop shift the
// whole row by one place. Pop-minimum and pop-maximum invalidate every copy of the
// extreme and then run DEPTH rounds of odd-even compaction between neighboring cells.
// After any removal a systolic scan chain running through the cells delivers the new
// extremes and count at cell 0. One request is in flight at a time; the next is taken
// the cycle after the response has been loaded into the output register, even while
// that response is still stalled. capacity_limit is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the block
// itself does not enforce this. It resets to 16 and saturates at DEPTH, and a limit
// of zero refuses every push.
module min_max_tracking_stack #(
	parameter int unsigned DEPTH = mmts_pkg::DEPTH_DEFAULT,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mmts_pkg::CAP_W-1:0]         cfg_wr_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [mmts_pkg::KIND_W-1:0]        kind,
	input  logic signed [mmts_pkg::DATA_W-1:0] value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [mmts_pkg::STATUS_W-1:0]      status,
	output logic signed [mmts_pkg::DATA_W-1:0] top_value,
	output logic signed [mmts_pkg::DATA_W-1:0] min_value,
	output logic signed [mmts_pkg::DATA_W-1:0] max_value,
	output logic [CNT_W-1:0]                   entry_count,
	output logic                               is_empty
);

	localparam int unsigned CMP_W = (CNT_W > mmts_pkg::CAP_W) ? CNT_W : mmts_pkg::CAP_W;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                         state_q;
	logic [CNT_W-1:0]                   cyc_q;
	logic [CNT_W-1:0]                   count_q;
	logic signed [mmts_pkg::DATA_W-1:0] min_q;
	logic signed [mmts_pkg::DATA_W-1:0] max_q;
	logic [mmts_pkg::CAP_W-1:0]         capacity_q;
	logic [mmts_pkg::STATUS_W-1:0]      result_status_q;

	// Output register.
	logic                               rsp_valid_q;
	logic [mmts_pkg::STATUS_W-1:0]      status_q;
	logic signed [mmts_pkg::DATA_W-1:0] top_q;
	logic signed [mmts_pkg::DATA_W-1:0] min_out_q;
	logic signed [mmts_pkg::DATA_W-1:0] max_out_q;
	logic [CNT_W-1:0]                   count_out_q;

	logic                               accept;
	logic                               load_rsp;
	logic                               push_full;
	logic [CMP_W-1:0]                   cap_eff;
	logic signed [mmts_pkg::DATA_W-1:0] victim;
	mmts_pkg::cell_ctrl_t               ctrl;

	// Cell row wiring. Index DEPTH is the bottom end of the scan chain.
	logic signed [mmts_pkg::DATA_W-1:0] cell_data  [DEPTH];
	logic                               cell_valid [DEPTH];
	mmts_pkg::scan_t                    scan_bus   [DEPTH+1];
	logic [CNT_W-1:0]                   scan_n_bus [DEPTH+1];

	assign accept   = req_valid && !req_stall;
	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// The effective limit saturates at the number of cells.
	always_comb begin
		if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end else begin
			cap_eff = CMP_W'(capacity_q);
		end
	end
	assign push_full = CMP_W'(count_q) >= cap_eff;

	assign victim = (kind == mmts_pkg::KIND_POP_MAX) ? max_q : min_q;

	// Command to the cells, decoded from the request in the accepting cycle and
	// from the round counter during compaction.
	always_comb begin
		ctrl = '0;
		if (accept) begin
			if (kind == mmts_pkg::KIND_PUSH) begin
				ctrl.shift_dn = !push_full;
			end else if (count_q != '0) begin
				ctrl.shift_up = (kind == mmts_pkg::KIND_POP);
				ctrl.mark     = (kind == mmts_pkg::KIND_POP_MIN) ||
					(kind == mmts_pkg::KIND_POP_MAX);
			end
		end else if (state_q == ST_SORT) begin
			ctrl.swap      = 1'b1;
			ctrl.phase_odd = cyc_q[0];
		end
	end

	assign scan_bus[DEPTH]   = '{lo: mmts_pkg::INT_MAX, hi: mmts_pkg::INT_MIN};
	assign scan_n_bus[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [mmts_pkg::DATA_W-1:0] up_data;
		logic                               up_valid;
		logic signed [mmts_pkg::DATA_W-1:0] dn_data;
		logic                               dn_valid;

		// The top cell sees the pushed value above it, flagged live so that it is
		// never the lower half of a compaction pair.
		if (i == 0) begin : g_top
			assign up_data  = value;
			assign up_valid = 1'b1;
		end else begin : g_mid
			assign up_data  = cell_data[i-1];
			assign up_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_bot
			assign dn_data  = '0;
			assign dn_valid = 1'b0;
		end else begin : g_low
			assign dn_data  = cell_data[i+1];
			assign dn_valid = cell_valid[i+1];
		end

		mmts_cell #(
			.CNT_W(CNT_W),
			.ODD  (1'(i % 2))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.victim    (victim),
			.up_data   (up_data),
			.up_valid  (up_valid),
			.dn_data   (dn_data),
			.dn_valid  (dn_valid),
			.data      (cell_data[i]),
			.valid     (cell_valid[i]),
			.scan_in   (scan_bus[i+1]),
			.scan_n_in (scan_n_bus[i+1]),
			.scan_out  (scan_bus[i]),
			.scan_n_out(scan_n_bus[i])
		);
	end

	// Sequencer. Push and query finish in the accepting cycle. Pop waits for the
	// scan chain to settle; pop-minimum and pop-maximum first run DEPTH rounds of
	// compaction, the last of which is the last change to the cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cyc_q           <= '0;
			count_q         <= '0;
			min_q           <= mmts_pkg::INT_MAX;
			max_q           <= mmts_pkg::INT_MIN;
			capacity_q      <= mmts_pkg::CAP_RESET;
			result_status_q <= mmts_pkg::STATUS_OK;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cyc_q           <= '0;
						result_status_q <= mmts_pkg::STATUS_OK;
						state_q         <= ST_DONE;
						if (kind == mmts_pkg::KIND_PUSH) begin
							if (push_full) begin
								result_status_q <= mmts_pkg::STATUS_OVERFLOW;
							end else begin
								count_q <= CNT_W'(count_q + 1'b1);
								if (value < min_q) begin
									min_q <= value;
								end
								if (value > max_q) begin
									max_q <= value;
								end
							end
						end else if (count_q == '0) begin
							result_status_q <= mmts_pkg::STATUS_UNDERFLOW;
						end else if (kind == mmts_pkg::KIND_POP) begin
							state_q <= ST_SCAN;
						end else if (kind == mmts_pkg::KIND_POP_MIN ||
							kind == mmts_pkg::KIND_POP_MAX) begin
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (cyc_q == CNT_W'(DEPTH - 1)) begin
						cyc_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						cyc_q <= CNT_W'(cyc_q + 1'b1);
					end
				end
				ST_SCAN: begin
					if (cyc_q == CNT_W'(DEPTH)) begin
						min_q   <= scan_bus[0].lo;
						max_q   <= scan_bus[0].hi;
						count_q <= scan_n_bus[0];
						state_q <= ST_DONE;
					end else begin
						cyc_q <= CNT_W'(cyc_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			status_q    <= result_status_q;
			top_q       <= cell_valid[0] ? cell_data[0] : '0;
			min_out_q   <= min_q;
			max_out_q   <= max_q;
			count_out_q <= count_q;
		end
	end

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign top_value   = top_q;
	assign min_value   = min_out_q;
	assign max_value   = max_out_q;
	assign entry_count = count_out_q;
	assign is_empty    = (count_out_q == '0);

endmodule

[hw/rtl/mmts_checker.sv]
module mmts_checker #(
	parameter int unsigned DEPTH = mmts_pkg::DEPTH_DEFAULT,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_wr_en,
	input logic [mmts_pkg::CAP_W-1:0]         cfg_wr_data,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic [mmts_pkg::KIND_W-1:0]        kind,
	input logic signed [mmts_pkg::DATA_W-1:0] value,
	input logic                               rsp_valid,
	input logic                               rsp_stall,
	input logic [mmts_pkg::STATUS_W-1:0]      status,
	input logic signed [mmts_pkg::DATA_W-1:0] top_value,
	input logic signed [mmts_pkg::DATA_W-1:0] min_value,
	input logic signed [mmts_pkg::DATA_W-1:0] max_value,
	input logic [CNT_W-1:0]                   entry_count,
	input logic                               is_empty
);

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(top_value) &&
			$stable(min_value) && $stable(max_value) && $stable(entry_count))
		else $error("stalled response changed");

	// An empty stack reports its sentinels and a zero top.
	a_empty_sentinels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> entry_count == '0 && top_value == '0 &&
			min_value == mmts_pkg::INT_MAX && max_value == mmts_pkg::INT_MIN)
		else $error("empty stack reports wrong extremes");

	// The top entry always lies between the tracked extremes.
	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_empty |-> min_value <= top_value && top_value <= max_value)
		else $error("top entry outside tracked extremes");

	// Underflow only ever happens on an empty stack.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == mmts_pkg::STATUS_UNDERFLOW |-> is_empty)
		else $error("underflow reported on a non-empty stack");

endmodule

bind min_max_tracking_stack mmts_checker #(.DEPTH(DEPTH)) u_mmts_checker (.*);
